// File: rtl/fractal_value_noise_assert.svh
// Assertion macros used by the checker file.
`ifndef FRACTAL_VALUE_NOISE_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define FVN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, live during reset as well.
`define FVN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fvn_pkg.sv
package fvn_pkg;

  localparam int MAX_OCTAVES = 6;
  localparam int FRAC_BITS   = 16;

  // frequency grows by less than 4x per octave, amplitude by less than 2x
  localparam int FW  = 17 + 2 * (MAX_OCTAVES - 1);
  localparam int AW  = 16 + MAX_OCTAVES - 1;
  localparam int PW  = 48 + FRAC_BITS;
  localparam int WW  = 16 + AW;
  localparam int LGO = $clog2(MAX_OCTAVES);
  localparam int SW  = WW + LGO;
  localparam int GW  = AW + LGO;

  localparam int DLY      = MAX_OCTAVES - 2;
  localparam int LANE_LAT = 8;
  localparam int DIV_LAT  = 16;
  localparam int PIPE_LAT = DLY + 4 + LANE_LAT + DIV_LAT;

  localparam logic [63:0] GOLD64      = 64'h9e3779b97f4a7c15;
  localparam logic [31:0] FMIX_LO     = 32'hed558ccd;
  localparam logic [31:0] FMIX_HI     = 32'hff51afd7;
  localparam logic [31:0] OCT_STEP    = 32'h009e3779;
  localparam logic [16:0] ONE16       = 17'h10000;
  localparam logic [15:0] BLEND_SCALE = 16'd42598;

  typedef enum logic [2:0] {
    REG_OCTAVE_COUNT = 3'd0,
    REG_START_FREQ   = 3'd1,
    REG_LACUNARITY   = 3'd2,
    REG_PERSISTENCE  = 3'd3,
    REG_BLEND_WEIGHT = 3'd4
  } cfg_reg_t;

  typedef logic [FW-1:0] freq_t;
  typedef logic [AW-1:0] amp_t;

  // boost-style combine of one lattice index into the running hash
  function automatic logic [63:0] hash_mix(input logic [63:0] h, input logic [31:0] idx);
    return h ^ ({{32{idx[31]}}, idx} + GOLD64 + (h << 6) + (h >> 2));
  endfunction

  function automatic logic [15:0] frac_q16(input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS+15:0] w;
    w = {f, 16'b0} >> FRAC_BITS;
    return w[15:0];
  endfunction

  // floor((a*(1-s) + b*s)) in Q0.16, s up to one
  function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                         input logic [16:0] s);
    logic signed [16:0] d;
    logic signed [35:0] m;
    logic signed [19:0] r;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    m = d * $signed({1'b0, s});
    r = $signed({4'b0, a}) + 20'(m >>> 16);
    return r[15:0];
  endfunction

endpackage

// File: rtl/fractal_value_noise.sv
// Channel  | Ports                                    | Transfer
// ---------+------------------------------------------+------------------------------
// input    | in_coord_x, in_coord_y, in_seed          | start && !busy at clk rise
// result   | out_noise_value                          | out_valid, one cycle, no stall
// config   | cfg_addr, cfg_wdata                      | cfg_we at clk rise
//
// One sample enters per cycle; busy is high only during reset and the cycle after.
// The pipeline is an input register and a delay line of MAX_OCTAVES-2 stages,
// eight stages of per-octave lanes, one sum stage, sixteen divider stages and
// two blend stages.
// Reset (rst_n low, synchronous) restores the configuration and control registers and empties the pipeline.
// The result side cannot stall, so the pipeline advances every cycle.
module fractal_value_noise (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_coord_x,
  input  logic signed [31:0]  in_coord_y,
  input  logic [31:0]         in_seed,
  output logic                out_valid,
  output logic [15:0]         out_noise_value,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [17:0]         cfg_wdata
);
  import fvn_pkg::*;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0]  octave_count_r;
  logic [16:0] start_frequency_r;
  logic [17:0] lacunarity_r;
  logic [16:0] persistence_r;
  logic [16:0] blend_weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r    <= 3'd2;
      start_frequency_r <= 17'd65536;
      lacunarity_r      <= 18'd104858;
      persistence_r     <= 17'd32768;
      blend_weight_r    <= 17'd0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_OCTAVE_COUNT: octave_count_r    <= cfg_wdata[2:0];
        REG_START_FREQ:   start_frequency_r <= cfg_wdata[16:0];
        REG_LACUNARITY:   lacunarity_r      <= cfg_wdata;
        REG_PERSISTENCE:  persistence_r     <= cfg_wdata[16:0];
        REG_BLEND_WEIGHT: blend_weight_r    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // per-octave frequency and amplitude tables: one multiply per link, free
  // running. After a write, entry i settles once the change has passed i links,
  // before any sample that follows it reaches the lanes through the delay line.
  // ---------------------------------------------------------------------------
  freq_t freq_w [MAX_OCTAVES];
  amp_t  amp_w  [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_tab
    if (i == 0) begin : g_base
      assign freq_w[i] = FW'(start_frequency_r);
      assign amp_w[i]  = AW'(ONE16);
    end else begin : g_link
      logic [FW+17:0] fp;
      logic [AW+16:0] ap;
      freq_t          freq_r;
      amp_t           amp_r;

      assign fp = freq_w[i-1] * lacunarity_r;
      assign ap = amp_w[i-1] * persistence_r;

      always_ff @(posedge clk) begin
        freq_r <= fp[16 +: FW];
        amp_r  <= ap[16 +: AW];
      end

      assign freq_w[i] = freq_r;
      assign amp_w[i]  = amp_r;
    end
  end

  // clamp the octave count and mask the unused lanes
  logic [3:0]             oc_ext, cnt_eff;
  logic [MAX_OCTAVES-1:0] lane_on;

  assign oc_ext  = 4'(octave_count_r);
  assign cnt_eff = (oc_ext < 4'd2) ? 4'd2 :
                   (oc_ext > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : oc_ext;

  always_comb begin
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      lane_on[i] = 4'(i) < cnt_eff;
    end
  end

  // total weight, registered from the amplitude table, and softening factor, registered from the blend weight
  logic [GW-1:0] weight_nxt, weight_r;
  logic [32:0]   kp;
  logic [16:0]   k_nxt, k_r;

  always_comb begin
    weight_nxt = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      weight_nxt = weight_nxt + (lane_on[i] ? GW'(amp_w[i]) : '0);
    end
  end

  assign kp    = blend_weight_r * BLEND_SCALE;
  assign k_nxt = (kp[32:16] > ONE16) ? ONE16 : kp[32:16];

  always_ff @(posedge clk) begin
    weight_r <= weight_nxt;
    k_r      <= k_nxt;
  end

  // ---------------------------------------------------------------------------
  // handshake and valid tracking
  // ---------------------------------------------------------------------------
  logic                accept;
  logic                busy_r;
  logic [PIPE_LAT-1:0] vld_r;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[PIPE_LAT-2:0], accept};
    end
  end

  assign busy      = busy_r;
  assign out_valid = vld_r[PIPE_LAT-1];

  // ---------------------------------------------------------------------------
  // input capture and delay line; hold nothing, advance every cycle
  // ---------------------------------------------------------------------------
  logic signed [31:0] cx_r   [DLY+1];
  logic signed [31:0] cy_r   [DLY+1];
  logic [31:0]        seed_r [DLY+1];

  always_ff @(posedge clk) begin
    cx_r[0]   <= in_coord_x;
    cy_r[0]   <= in_coord_y;
    seed_r[0] <= in_seed;
    for (int j = 1; j <= DLY; j++) begin
      cx_r[j]   <= cx_r[j-1];
      cy_r[j]   <= cy_r[j-1];
      seed_r[j] <= seed_r[j-1];
    end
  end

  // ---------------------------------------------------------------------------
  // octave lanes, all in parallel; each lane has its own seed offset
  // ---------------------------------------------------------------------------
  logic [WW-1:0] wsample [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    logic [31:0] lane_seed;

    assign lane_seed = seed_r[DLY] + OCT_STEP * 32'(i);

    fvn_octave u_octave (
      .clk     (clk),
      .coord_x (cx_r[DLY]),
      .coord_y (cy_r[DLY]),
      .seed    (lane_seed),
      .freq    (freq_w[i]),
      .amp     (amp_w[i]),
      .wsample (wsample[i])
    );
  end

  // sum the active lanes
  logic [SW-1:0] sum_nxt, sum_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      sum_nxt = sum_nxt + (lane_on[i] ? SW'(wsample[i]) : '0);
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // weighted mean; the first octave always weighs one, so the divisor is never zero
  logic [15:0] mean;

  fvn_div u_div (
    .clk      (clk),
    .dividend (sum_r),
    .divisor  (weight_r),
    .quotient (mean)
  );

  // soften toward the square: n + (n*n - n) * k, then drive the result
  logic [31:0] sq;
  logic [15:0] n_r, nn_r, noise_r;

  assign sq = mean * mean;

  always_ff @(posedge clk) begin
    n_r     <= mean;
    nn_r    <= sq[31:16];
    noise_r <= lerp16(n_r, nn_r, k_r);
  end

  assign out_noise_value = noise_r;

endmodule

// File: rtl/fvn_octave.sv
module fvn_octave (
  input  logic                    clk,
  input  logic signed [31:0]      coord_x,
  input  logic signed [31:0]      coord_y,
  input  logic [31:0]             seed,
  input  fvn_pkg::freq_t          freq,
  input  fvn_pkg::amp_t           amp,
  output logic [fvn_pkg::WW-1:0]  wsample
);
  import fvn_pkg::*;

  // stage 1: scale the point
  logic signed [FW+32:0] px_full, py_full;
  logic signed [PW-1:0]  px_r, py_r;
  logic [31:0]           seed_r;

  assign px_full = coord_x * $signed({1'b0, freq});
  assign py_full = coord_y * $signed({1'b0, freq});

  always_ff @(posedge clk) begin
    px_r   <= PW'(px_full);
    py_r   <= PW'(py_full);
    seed_r <= seed;
  end

  // stage 2: lattice indices, first hash round, fraction squares
  logic [31:0] xi, xn, yi;
  logic [15:0] tx, ty;
  logic [31:0] sqx, sqy;
  logic [63:0] h0;
  logic [63:0] h1a_r, h1b_r;
  logic [31:0] yi_r, yn_r;
  logic [15:0] tx_r, ty_r, t2x_r, t2y_r;

  assign xi  = px_r[16+FRAC_BITS +: 32];
  assign yi  = py_r[16+FRAC_BITS +: 32];
  assign xn  = xi + 32'd1;
  assign tx  = frac_q16(px_r[16 +: FRAC_BITS]);
  assign ty  = frac_q16(py_r[16 +: FRAC_BITS]);
  assign sqx = tx * tx;
  assign sqy = ty * ty;
  assign h0  = {32'b0, seed_r};

  always_ff @(posedge clk) begin
    h1a_r <= hash_mix(h0, xi);
    h1b_r <= hash_mix(h0, xn);
    yi_r  <= yi;
    yn_r  <= yi + 32'd1;
    tx_r  <= tx;
    ty_r  <= ty;
    t2x_r <= sqx[31:16];
    t2y_r <= sqy[31:16];
  end

  // stage 3: second hash round per corner, smoothstep
  logic [17:0] fx, fy;
  logic [33:0] smx, smy;
  logic [63:0] h2_r [4];
  logic [16:0] sx3_r, sy3_r;

  assign fx  = 18'd196608 - {1'b0, tx_r, 1'b0};
  assign fy  = 18'd196608 - {1'b0, ty_r, 1'b0};
  assign smx = t2x_r * fx;
  assign smy = t2y_r * fy;

  always_ff @(posedge clk) begin
    h2_r[0] <= hash_mix(h1a_r, yi_r);
    h2_r[1] <= hash_mix(h1b_r, yi_r);
    h2_r[2] <= hash_mix(h1a_r, yn_r);
    h2_r[3] <= hash_mix(h1b_r, yn_r);
    sx3_r   <= smx[32:16];
    sy3_r   <= smy[32:16];
  end

  // stage 4: finalizer multiply as 32-bit partial products
  logic [63:0] g    [4];
  logic [63:0] pl_r [4];
  logic [31:0] pm_r [4];
  logic [16:0] sx4_r, sy4_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      g[k] = h2_r[k] ^ (h2_r[k] >> 33);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pl_r[k] <= {32'b0, g[k][31:0]} * {32'b0, FMIX_LO};
      pm_r[k] <= g[k][31:0] * FMIX_HI + g[k][63:32] * FMIX_LO;
    end
    sx4_r <= sx3_r;
    sy4_r <= sy3_r;
  end

  // stage 5: combine partials, keep the top 16 bits as corner value
  logic [63:0] hf  [4];
  logic [15:0] v_r [4];
  logic [16:0] sx5_r, sy5_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hf[k] = pl_r[k] + {pm_r[k], 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      v_r[k] <= hf[k][63:48];
    end
    sx5_r <= sx4_r;
    sy5_r <= sy4_r;
  end

  // stages 6..8: blend along x, then y, then weight by amplitude
  logic [15:0]     hx0_r, hx1_r, smp_r;
  logic [16:0]     sy6_r;
  logic [WW-1:0]   wsample_r;

  always_ff @(posedge clk) begin
    hx0_r     <= lerp16(v_r[0], v_r[1], sx5_r);
    hx1_r     <= lerp16(v_r[2], v_r[3], sx5_r);
    sy6_r     <= sy5_r;
    smp_r     <= lerp16(hx0_r, hx1_r, sy6_r);
    wsample_r <= smp_r * amp;
  end

  assign wsample = wsample_r;

endmodule

// File: rtl/fvn_div.sv
module fvn_div (
  input  logic                    clk,
  input  logic [fvn_pkg::SW-1:0]  dividend,
  input  logic [fvn_pkg::GW-1:0]  divisor,
  output logic [15:0]             quotient
);
  import fvn_pkg::*;

  // restoring division, one quotient bit per stage, msb first
  logic [SW-1:0] rem_in [DIV_LAT];
  logic [15:0]   q_in   [DIV_LAT];
  logic [SW-1:0] rem_r  [DIV_LAT-1];
  logic [15:0]   q_r    [DIV_LAT];

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
    logic [SW-1:0] cand;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in[j] = dividend;
      assign q_in[j]   = '0;
    end else begin : g_next
      assign rem_in[j] = rem_r[j-1];
      assign q_in[j]   = q_r[j-1];
    end

    assign cand = SW'(divisor) << (DIV_LAT - 1 - j);
    assign ge   = rem_in[j] >= cand;

    always_ff @(posedge clk) begin
      q_r[j] <= q_in[j] | (16'(ge) << (DIV_LAT - 1 - j));
    end

    if (j < DIV_LAT - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[j] <= ge ? rem_in[j] - cand : rem_in[j];
      end
    end
  end

  assign quotient = q_r[DIV_LAT-1];

endmodule

// File: rtl/fvn_checker.sv
`include "fractal_value_noise_assert.svh"

module fvn_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import fvn_pkg::*;

  // every result traces back to an earlier transfer on the input channel
  `FVN_ASSERT_IMP(a_out_after_in, out_valid, $past(start && !busy, PIPE_LAT), "orphan result")

  // reset raises busy and empties the pipeline
  `FVN_ASSERT_NXT(a_busy_in_reset, !rst_n, busy, "busy low after reset edge")
  `FVN_ASSERT_NXT(a_quiet_after_reset, !rst_n, !out_valid, "result right after reset")

  // once out of reset the block takes a sample every cycle
  `FVN_ASSERT_IMP(a_ready_after_reset, $past(rst_n), !busy, "busy outside reset")

endmodule

bind fractal_value_noise fvn_checker u_fvn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
